// File: rtl/crax_block_cipher_core_defines.svh
// Assertion helpers shared by the RTL files.
`ifndef CRAX_BLOCK_CIPHER_CORE_DEFINES_SVH
`define CRAX_BLOCK_CIPHER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CRAX_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define CRAX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/crax_pkg.sv
package crax_pkg;

    // Default number of cipher steps
    localparam int STEP_COUNT_DEF = 10;

    // ARX rounds inside one Alzette box
    localparam int ROUNDS_PER_STEP = 4;

    // Configuration register indexes
    localparam logic [1:0] REG_KEY0 = 2'd0;
    localparam logic [1:0] REG_KEY1 = 2'd1;
    localparam logic [1:0] REG_KEY2 = 2'd2;
    localparam logic [1:0] REG_KEY3 = 2'd3;

    // Round constants, one per step modulo five
    localparam logic [31:0] RCON_TABLE [5] = '{
        32'hB7E15162, 32'hBF715880, 32'h38B4DA56, 32'h324E7738, 32'hBB1185EB
    };

    // Right-rotate amounts of the Alzette rounds: add term and xor term
    localparam int ROT_ADD [4] = '{31, 17, 0, 24};
    localparam int ROT_XOR [4] = '{24, 17, 31, 16};

    // Key words as held by the core
    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } crax_key_t;

    // One item moving along the cell chain
    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [31:0] left;
        logic [31:0] right;
    } crax_item_t;

    // Rotate a 32-bit word right by a constant amount
    function automatic logic [31:0] rotr32(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

// File: rtl/crax_cell.sv
module crax_cell
    import crax_pkg::*;
#(
    parameter int STEP_COUNT = STEP_COUNT_DEF,
    parameter int POS        = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  crax_key_t  keys,
    input  crax_item_t up,
    output logic       up_ready,
    output crax_item_t down,
    input  logic       down_ready
);

    localparam int CELL_COUNT = STEP_COUNT * ROUNDS_PER_STEP;

    // Encrypt schedule: steps in forward order
    localparam int          ENC_STEP  = POS / ROUNDS_PER_STEP;
    localparam int          ENC_RND   = POS % ROUNDS_PER_STEP;
    localparam bit          ENC_ODD   = (ENC_STEP % 2) == 1;
    localparam bit          ENC_FIRST = ENC_RND == 0;
    localparam bit          ENC_LAST  = POS == CELL_COUNT - 1;
    localparam logic [31:0] ENC_RC    = RCON_TABLE[ENC_STEP % 5];
    localparam logic [31:0] ENC_SIDX  = 32'(ENC_STEP);

    // Decrypt schedule: steps in reverse order, rounds undone last to first
    localparam int          DEC_STEP  = STEP_COUNT - 1 - ENC_STEP;
    localparam int          DEC_RND   = ROUNDS_PER_STEP - 1 - ENC_RND;
    localparam bit          DEC_ODD   = (DEC_STEP % 2) == 1;
    localparam bit          DEC_FIRST = POS == 0;
    localparam bit          DEC_END   = DEC_RND == 0;
    localparam logic [31:0] DEC_RC    = RCON_TABLE[DEC_STEP % 5];
    localparam logic [31:0] DEC_SIDX  = 32'(DEC_STEP);

    crax_item_t item_reg;
    crax_item_t item_next;
    logic       valid_reg;
    logic [31:0] ex, ey, dx, dy;

    // Compute one forward and one inverse round, select by kind
    always_comb
    begin
        ex = up.left;
        ey = up.right;
        if (ENC_FIRST)
        begin
            ex = ex ^ (ENC_ODD ? keys.k2 : keys.k0) ^ ENC_SIDX;
            ey = ey ^ (ENC_ODD ? keys.k3 : keys.k1);
        end
        ex = ex + rotr32(ey, ROT_ADD[ENC_RND]);
        ey = ey ^ rotr32(ex, ROT_XOR[ENC_RND]);
        ex = ex ^ ENC_RC;
        if (ENC_LAST)
        begin
            ex = ex ^ keys.k0;
            ey = ey ^ keys.k1;
        end

        dx = up.left;
        dy = up.right;
        if (DEC_FIRST)
        begin
            dx = dx ^ keys.k0;
            dy = dy ^ keys.k1;
        end
        dx = dx ^ DEC_RC;
        dy = dy ^ rotr32(dx, ROT_XOR[DEC_RND]);
        dx = dx - rotr32(dy, ROT_ADD[DEC_RND]);
        if (DEC_END)
        begin
            dx = dx ^ (DEC_ODD ? keys.k2 : keys.k0) ^ DEC_SIDX;
            dy = dy ^ (DEC_ODD ? keys.k3 : keys.k1);
        end

        item_next.valid = up.valid;
        item_next.kind  = up.kind;
        item_next.left  = up.kind ? dx : ex;
        item_next.right = up.kind ? dy : ey;
    end

    // Take a new item when empty or when the neighbor takes ours
    assign up_ready = !valid_reg || down_ready;

    // Hold occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up.valid;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up.valid)
        begin
            item_reg <= item_next;
        end
    end

    always_comb
    begin
        down       = item_reg;
        down.valid = valid_reg;
    end

endmodule

// File: rtl/crax_block_cipher_core.sv
// CRAX-S-10 block cipher core. Each item is one 64-bit block (left_in, right_in)
// with kind selecting encrypt (0) or decrypt (1) under the 128-bit key in
// registers 0..3. The core is a chain of 4*STEP_COUNT cells, one Alzette ARX
// round per cell. An accepted item is registered by each cell in turn, and
// out_valid is the valid bit held by the last cell. A new item is accepted
// every cycle while the output side keeps up. A cell holding an item moves it
// on as soon as its neighbor is free. A stall on the output holds every full
// cell back in the same cycle while empty cells still fill, so in_stall rises
// only once the whole chain is full. Key words are read by every cell directly,
// so write them only while no item is in flight.
`include "crax_block_cipher_core_defines.svh"

module crax_block_cipher_core
    import crax_pkg::*;
#(
    parameter int STEP_COUNT = STEP_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] left_in,
    input  logic [31:0] right_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] left_out,
    output logic [31:0] right_out
);

    localparam int CELL_COUNT = STEP_COUNT * ROUNDS_PER_STEP;

    crax_key_t               key_reg;
    crax_item_t              bus [CELL_COUNT + 1];
    logic [CELL_COUNT:0]     rdy;

    // Write key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY0: key_reg.k0 <= cfg_data;
                REG_KEY1: key_reg.k1 <= cfg_data;
                REG_KEY2: key_reg.k2 <= cfg_data;
                REG_KEY3: key_reg.k3 <= cfg_data;
                default:  key_reg    <= key_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Feed the chain
    always_comb
    begin
        bus[0].valid = in_valid;
        bus[0].kind  = kind;
        bus[0].left  = left_in;
        bus[0].right = right_in;
    end

    assign rdy[CELL_COUNT] = !out_stall;
    assign in_stall        = !rdy[0];

    // Build the cell chain
    for (genvar i = 0; i < CELL_COUNT; i++)
    begin : g_cell
        crax_cell #(
            .STEP_COUNT (STEP_COUNT),
            .POS        (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .keys       (key_reg),
            .up         (bus[i]),
            .up_ready   (rdy[i]),
            .down       (bus[i + 1]),
            .down_ready (rdy[i + 1])
        );
    end

    // Drive the result from the last cell
    assign out_valid = bus[CELL_COUNT].valid;
    assign left_out  = bus[CELL_COUNT].left;
    assign right_out = bus[CELL_COUNT].right;

    `CRAX_ASSERT_SAME(a_flow_through, !out_stall, !in_stall, "chain stalls with output free")
    `CRAX_ASSERT_SAME(a_empty_takes, !bus[1].valid, !in_stall, "empty first cell refuses item")
    `CRAX_ASSERT_SAME(a_out_source, $rose(out_valid), $past(bus[CELL_COUNT - 1].valid),
        "result appeared with no item in the cell before")

endmodule

// File: tb/sv/crax_cipher_checker.sv
`timescale 1ns / 1ps

package crax_tb_pkg;

    // Operation carried in the kind field of an input item
    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } cipher_op_e;

endpackage

module crax_cipher_checker
    import crax_pkg::*;
    import crax_tb_pkg::*;
#(
    parameter int STEPS = STEP_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [31:0] left_in,
    input  logic [31:0] right_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] left_out,
    input  logic [31:0] right_out,
    output int          fail_count,
    output int          outstanding,
    output int          checked
);

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
    } block_t;

    // Step constants, reused every five steps
    localparam logic [31:0] STEP_RCON [5] = '{
        32'hB7E15162, 32'hBF715880, 32'h38B4DA56, 32'h324E7738, 32'hBB1185EB
    };

    // Right-rotate amounts of the four box rounds
    localparam int ADD_ROT [4] = '{31, 17, 0, 24};
    localparam int XOR_ROT [4] = '{24, 17, 31, 16};

    logic [31:0] key_word [4] = '{32'h0, 32'h0, 32'h0, 32'h0};
    block_t      pending_blocks [$];
    int          fail_total    = 0;
    int          checked_total = 0;

    function automatic logic [31:0] ror32(logic [31:0] w, int n);
        logic [63:0] twice;
        twice = {w, w} >> n;
        return twice[31:0];
    endfunction

    function automatic void box_forward(inout logic [31:0] a, inout logic [31:0] b,
                                        input logic [31:0] c);
        for (int i = 0; i < 4; i++)
        begin
            a = a + ror32(b, ADD_ROT[i]);
            b = b ^ ror32(a, XOR_ROT[i]);
            a = a ^ c;
        end
    endfunction

    function automatic void box_inverse(inout logic [31:0] a, inout logic [31:0] b,
                                        input logic [31:0] c);
        for (int i = 3; i >= 0; i--)
        begin
            a = a ^ c;
            b = b ^ ror32(a, XOR_ROT[i]);
            a = a - ror32(b, ADD_ROT[i]);
        end
    endfunction

    // Compute the result block for one input item under the current key
    function automatic block_t cipher_block(cipher_op_e op, logic [31:0] l, logic [31:0] r);
        logic [31:0] x;
        logic [31:0] y;
        block_t      res;
        x = l;
        y = r;
        if (op == OP_ENCRYPT)
        begin
            for (int s = 0; s < STEPS; s++)
            begin
                x = x ^ ((s % 2 == 1) ? key_word[2] : key_word[0]) ^ 32'(s);
                y = y ^ ((s % 2 == 1) ? key_word[3] : key_word[1]);
                box_forward(x, y, STEP_RCON[s % 5]);
            end
            x = x ^ key_word[0];
            y = y ^ key_word[1];
        end
        else
        begin
            x = x ^ key_word[0];
            y = y ^ key_word[1];
            for (int s = STEPS - 1; s >= 0; s--)
            begin
                box_inverse(x, y, STEP_RCON[s % 5]);
                x = x ^ ((s % 2 == 1) ? key_word[2] : key_word[0]) ^ 32'(s);
                y = y ^ ((s % 2 == 1) ? key_word[3] : key_word[1]);
            end
        end
        res.left  = x;
        res.right = y;
        return res;
    endfunction

    // Print one line per mismatch and count it
    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        fail_total++;
    endtask

    // Track key writes, predict each accepted item, compare each accepted result
    always @(posedge clk)
    begin : monitor
        block_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KEY0: key_word[0] = cfg_data;
                    REG_KEY1: key_word[1] = cfg_data;
                    REG_KEY2: key_word[2] = cfg_data;
                    REG_KEY3: key_word[3] = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_blocks.size() == 0)
                    report_error($sformatf("result %08h %08h with no item pending",
                                           left_out, right_out));
                else
                begin
                    want = pending_blocks.pop_front();
                    checked_total++;
                    if (left_out !== want.left)
                        report_error($sformatf("left_out %08h, predicted %08h",
                                               left_out, want.left));
                    if (right_out !== want.right)
                        report_error($sformatf("right_out %08h, predicted %08h",
                                               right_out, want.right));
                end
            end
            if (in_valid && !in_stall)
                pending_blocks.push_back(cipher_block(cipher_op_e'(kind), left_in, right_in));
        end
        outstanding <= pending_blocks.size();
        fail_count  <= fail_total;
        checked     <= checked_total;
    end

endmodule

// File: tb/sv/tb_crax_block_cipher_core.sv
`timescale 1ns / 1ps

module tb_crax_block_cipher_core;
    import crax_pkg::*;
    import crax_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 116;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 60;

    localparam logic [1:0] KEY_REGS [4] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_KEY0;
    logic [31:0] cfg_data  = 32'h0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        kind      = OP_ENCRYPT;
    logic [31:0] left_in   = 32'h0;
    logic [31:0] right_in  = 32'h0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] left_out;
    logic [31:0] right_out;

    int fail_count;
    int outstanding;
    int checked;

    // Stimulus controls read by the receiver
    logic quiet    = 1'b0;
    logic hold_req = 1'b0;

    int cycle_count = 0;
    int sent_total  = 0;
    int sent_dec    = 0;
    int key_loads   = 0;

    always #6 clk = ~clk;

    crax_block_cipher_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out)
    );

    crax_cipher_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .left_in     (left_in),
        .right_in    (right_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_out    (left_out),
        .right_out   (right_out),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("tb_crax_block_cipher_core: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off on request, none while quiet
    initial
    begin : receiver
        int  hold_left;
        bit  hold_served;
        hold_left   = 0;
        hold_served = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_served)
            begin
                hold_left   = HOLD_CYCLES;
                hold_served = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 20);
        end
    end

    // Offer one item and hold it until the core takes it
    task automatic send_block(input cipher_op_e op, input logic [31:0] l, input logic [31:0] r);
        while (!quiet && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        left_in  <= l;
        right_in <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_total++;
        if (op == OP_DECRYPT)
            sent_dec++;
    endtask

    // Stop offering and wait until every result is back and the chain is empty
    task automatic drain_core();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all four key words, core idle
    task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
        logic [31:0] words [4];
        words = '{k0, k1, k2, k3};
        foreach (words[i])
        begin
            cfg_valid <= 1'b1;
            cfg_index <= KEY_REGS[i];
            cfg_data  <= words[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
        key_loads++;
    endtask

    // Edge-case blocks under both operations
    task automatic run_directed();
        logic [31:0] lefts  [6];
        logic [31:0] rights [6];
        lefts  = '{32'h0, 32'hFFFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF, 32'hAAAAAAAA};
        rights = '{32'h0, 32'hFFFFFFFF, 32'h00000001, 32'h80000000, 32'h00000000, 32'h55555555};
        for (int i = 0; i < 6; i++)
        begin
            send_block(OP_ENCRYPT, lefts[i], rights[i]);
            send_block(OP_DECRYPT, lefts[i], rights[i]);
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h0;
            1:       return 32'hFFFFFFFF;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin : stimulus
        cipher_op_e op;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed blocks under the reset key, then under the all-ones key
        run_directed();
        drain_core();
        load_key(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        run_directed();

        // Random blocks over several key settings
        for (int ph = 0; ph < 8; ph++)
        begin
            drain_core();
            case (ph)
                0:       load_key(32'h80000000, 32'h00000001, 32'hAAAAAAAA, 32'h55555555);
                3:       load_key(32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000);
                6:       load_key(32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF);
                7:       load_key(32'h0, 32'h0, 32'h0, 32'h0);
                default: load_key($urandom(), $urandom(), $urandom(), $urandom());
            endcase
            quiet <= (ph == 2);
            if (ph == 4)
                hold_req <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Pause mid-phase until every result is back
                if (ph == 5 && n == PHASE_ITEMS / 2)
                    drain_core();
                op = cipher_op_e'($urandom_range(1));
                send_block(op, pick_word(), pick_word());
            end
        end

        // Wait for the last results, then let the chain settle
        in_valid <= 1'b0;
        quiet    <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("sent %0d blocks (%0d decrypt) across %0d key loads plus reset key",
                 sent_total, sent_dec, key_loads);
        $display("checked %0d results, with a %0d-cycle output hold-off and a full drain",
                 checked, HOLD_CYCLES);
        if (fail_count == 0)
            $display("tb_crax_block_cipher_core: done, clean");
        else
            $display("tb_crax_block_cipher_core: done, errors");
        $finish;
    end

endmodule
